// ===== rtl/core/cse_pkg.sv =====
// Shared constants, payload types and control structs of the silhouette engine.
package cse_pkg;

	localparam int MAX_FRAMES   = 48;
	localparam int MAX_CLUSTERS = 8;
	localparam int DIST_BITS    = 16;

	localparam int FR_W    = 6;
	localparam int CL_W    = 3;
	localparam int NC_W    = 4;
	localparam int VAL_W   = 16;
	localparam int CNT_W   = $clog2(MAX_FRAMES);
	localparam int SUM_W   = DIST_BITS + CNT_W;
	localparam int PRD_W   = SUM_W + CNT_W;
	localparam int ADDR_W  = $clog2(MAX_FRAMES * MAX_FRAMES);
	localparam int QBITS   = 15;
	localparam int NUM_W   = PRD_W + QBITS;
	localparam int STEP_W  = $clog2(QBITS);
	localparam int AVG_W   = VAL_W + CNT_W;
	localparam int ONE_Q14 = 16384;

	localparam logic [1:0] OP_LOAD_DIST = 2'd0;
	localparam logic [1:0] OP_LOAD_INFO = 2'd1;
	localparam logic [1:0] OP_RUN       = 2'd2;

	localparam logic [1:0] KIND_FRAME = 2'd0;
	localparam logic [1:0] KIND_AVG   = 2'd1;
	localparam logic [1:0] KIND_SKIP  = 2'd2;

	localparam logic [1:0] CFG_FRAMES   = 2'd0;
	localparam logic [1:0] CFG_CLUSTERS = 2'd1;
	localparam logic [1:0] CFG_SIEVED   = 2'd2;

	localparam logic [2:0] EM_NONE = 3'd0;
	localparam logic [2:0] EM_ONE  = 3'd1;
	localparam logic [2:0] EM_SKIP = 3'd2;
	localparam logic [2:0] EM_DIV  = 3'd3;
	localparam logic [2:0] EM_AVG0 = 3'd4;

	typedef struct packed {
		logic [1:0]           opcode;
		logic [FR_W-1:0]      frame_a;
		logic [FR_W-1:0]      frame_b;
		logic [DIST_BITS-1:0] distance;
		logic [CL_W-1:0]      cluster_id;
		logic                 is_present;
		logic                 is_assigned;
	} req_t;

	typedef struct packed {
		logic [1:0]        kind;
		logic [FR_W-1:0]   frame_index;
		logic [CL_W-1:0]   cluster_index;
		logic signed [VAL_W-1:0] value;
		logic              last;
	} res_t;

	typedef struct packed {
		logic [CL_W-1:0] cluster;
		logic            present;
		logic            assigned;
	} info_t;

	typedef struct packed {
		logic       wr_dist;
		logic       wr_dist2;
		logic       wr_info;
		logic       run_init;
		logic       f_rd;
		logic       f_inc;
		logic       c_next;
		logic       sw_init;
		logic       sw_issue;
		logic       b_init;
		logic       b_step;
		logic       pq;
		logic       div_frame_init;
		logic       div_avg_init;
		logic       div_step;
		logic [2:0] emit_sel;
	} cmd_t;

	typedef struct packed {
		logic f_last;
		logic g_last;
		logic j_last;
		logic c_last;
		logic nf_zero;
		logic nc_zero;
		logic f_sel;
		logic have_b;
		logic den_zero;
		logic avg_zero;
		logic div_last;
		logic avg_mode;
	} sts_t;

endpackage

// ===== rtl/core/cluster_silhouette_engine_unit.sv =====
// Top level of the silhouette engine: sequencer plus datapath.
//
// Requests enter on start/req and are taken when start is high and busy is low.
// A distance-pair load keeps busy high while the mirrored entry is written; a
// frame-info load leaves busy low. A run walks clusters in ascending order; for
// each counted frame it sweeps the stored row of the distance matrix, one entry
// per cycle, drains the last read, searches the nearest other cluster, then
// divides unless the frame scores +1 or is skipped. Each cluster adds a frame
// scan over the frames it does not own, then divides for its average unless it
// has no frame values. The distance store has a single memory read port.
// Results appear on result for exactly one cycle, flagged by result_valid; the
// receiver cannot stall them. result.last marks the final result of a run.
// Configuration is written through cfg_we/cfg_index/cfg_data while idle.
// Reset clears configuration to its defaults and marks all frame info unwritten,
// which reads as zero; the distance store is undefined until loaded.
module cluster_silhouette_engine_unit import cse_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  req_t       req,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [5:0] cfg_data,
	output logic       result_valid,
	output res_t       result
);

	cmd_t cmd;
	sts_t sts;

	cse_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.opcode (req.opcode),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	cse_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.req          (req),
		.cmd          (cmd),
		.sts          (sts),
		.result_valid (result_valid),
		.result       (result)
	);

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.last |-> !busy)
		else $error("final result shown while still busy");

	a_start_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> !result_valid)
		else $error("result appeared right after an accepted request");

	a_value_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.value <= 16'sd16384) && (result.value >= -16'sd16384))
		else $error("silhouette value out of range");

	a_kind_code: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.kind == KIND_FRAME) || (result.kind == KIND_AVG) ||
			(result.kind == KIND_SKIP))
		else $error("undefined result kind");

endmodule

// ===== rtl/core/cse_ctrl.sv =====
// Sequencer of the silhouette engine: loads, frame scan, sweeps, search and division.
module cse_ctrl import cse_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [1:0] opcode,
	input  sts_t       sts,
	output cmd_t       cmd,
	output logic       busy
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_WR2   = 4'd1;
	localparam logic [3:0] S_FRD   = 4'd2;
	localparam logic [3:0] S_FCHK  = 4'd3;
	localparam logic [3:0] S_SWEEP = 4'd4;
	localparam logic [3:0] S_DRAIN = 4'd5;
	localparam logic [3:0] S_BSRCH = 4'd6;
	localparam logic [3:0] S_PQ    = 4'd7;
	localparam logic [3:0] S_DEC   = 4'd8;
	localparam logic [3:0] S_DIV   = 4'd9;
	localparam logic [3:0] S_EMIT  = 4'd10;
	localparam logic [3:0] S_AVG   = 4'd11;

	logic [3:0] state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					unique case (opcode)
						OP_LOAD_DIST: begin
							cmd.wr_dist = 1'b1;
							state_d     = S_WR2;
						end
						OP_LOAD_INFO: cmd.wr_info = 1'b1;
						OP_RUN: begin
							if (!sts.nc_zero) begin
								cmd.run_init = 1'b1;
								state_d      = sts.nf_zero ? S_AVG : S_FRD;
							end
						end
						default: ;
					endcase
				end
			end
			S_WR2: begin
				cmd.wr_dist2 = 1'b1;
				state_d      = S_IDLE;
			end
			S_FRD: begin
				cmd.f_rd = 1'b1;
				state_d  = S_FCHK;
			end
			S_FCHK: begin
				priority if (sts.f_sel) begin
					cmd.sw_init = 1'b1;
					state_d     = S_SWEEP;
				end else if (sts.f_last) begin
					state_d = S_AVG;
				end else begin
					cmd.f_inc = 1'b1;
					state_d   = S_FRD;
				end
			end
			S_SWEEP: begin
				cmd.sw_issue = 1'b1;
				if (sts.g_last) state_d = S_DRAIN;
			end
			S_DRAIN: begin
				cmd.b_init = 1'b1;
				state_d    = S_BSRCH;
			end
			S_BSRCH: begin
				cmd.b_step = 1'b1;
				if (sts.j_last) state_d = S_PQ;
			end
			S_PQ: begin
				cmd.pq  = 1'b1;
				state_d = S_DEC;
			end
			S_DEC: begin
				priority if (!sts.have_b || sts.den_zero) begin
					cmd.emit_sel = sts.have_b ? EM_SKIP : EM_ONE;
					if (sts.f_last) begin
						state_d = S_AVG;
					end else begin
						cmd.f_inc = 1'b1;
						state_d   = S_FRD;
					end
				end else begin
					cmd.div_frame_init = 1'b1;
					state_d            = S_DIV;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) state_d = S_EMIT;
			end
			S_EMIT: begin
				cmd.emit_sel = EM_DIV;
				priority if (sts.avg_mode) begin
					if (sts.c_last) begin
						state_d = S_IDLE;
					end else begin
						cmd.c_next = 1'b1;
						state_d    = sts.nf_zero ? S_AVG : S_FRD;
					end
				end else if (sts.f_last) begin
					state_d = S_AVG;
				end else begin
					cmd.f_inc = 1'b1;
					state_d   = S_FRD;
				end
			end
			S_AVG: begin
				priority if (sts.avg_zero) begin
					cmd.emit_sel = EM_AVG0;
					if (sts.c_last) begin
						state_d = S_IDLE;
					end else begin
						cmd.c_next = 1'b1;
						state_d    = sts.nf_zero ? S_AVG : S_FRD;
					end
				end else begin
					cmd.div_avg_init = 1'b1;
					state_d          = S_DIV;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign busy = (state_q != S_IDLE);

endmodule

// ===== rtl/core/cse_dp.sv =====
// Datapath of the silhouette engine: stores, sweep sums, nearest-cluster search, divider.
module cse_dp import cse_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [5:0] cfg_data,
	input  req_t       req,
	input  cmd_t       cmd,
	output sts_t       sts,
	output logic       result_valid,
	output res_t       result
);

	logic [FR_W-1:0] fiu_q;
	logic [NC_W-1:0] ciu_q;
	logic            incl_q;
	logic [FR_W-1:0] nf;
	logic [NC_W-1:0] nc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fiu_q  <= FR_W'(48);
			ciu_q  <= NC_W'(2);
			incl_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_FRAMES:   fiu_q  <= cfg_data[FR_W-1:0];
				CFG_CLUSTERS: ciu_q  <= cfg_data[NC_W-1:0];
				CFG_SIEVED:   incl_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign nf = (int'(fiu_q) > MAX_FRAMES) ? FR_W'(MAX_FRAMES) : fiu_q;
	assign nc = (int'(ciu_q) > MAX_CLUSTERS) ? NC_W'(MAX_CLUSTERS) : ciu_q;

	// Distance store; a pair load writes the mirrored entry in the following cycle.
	logic [DIST_BITS-1:0] dist_mem [MAX_FRAMES*MAX_FRAMES];
	logic [DIST_BITS-1:0] dist_rd_q;
	logic [DIST_BITS-1:0] wdata2_q;
	logic [ADDR_W-1:0]    waddr2_q;
	logic                 pair_ok_q;
	logic                 pair_ok;
	logic                 dwe;
	logic [ADDR_W-1:0]    dwaddr;
	logic [ADDR_W-1:0]    draddr;
	logic [FR_W-1:0]      f_q, g_q;
	logic [CL_W-1:0]      c_q, j_q;

	assign pair_ok = (int'(req.frame_a) < MAX_FRAMES) && (int'(req.frame_b) < MAX_FRAMES);
	assign dwe     = (cmd.wr_dist && pair_ok) || (cmd.wr_dist2 && pair_ok_q);
	assign dwaddr  = cmd.wr_dist ?
		ADDR_W'(req.frame_a) * ADDR_W'(MAX_FRAMES) + ADDR_W'(req.frame_b) : waddr2_q;
	assign draddr  = ADDR_W'(f_q) * ADDR_W'(MAX_FRAMES) + ADDR_W'(g_q);

	always_ff @(posedge clk) begin
		if (cmd.wr_dist) begin
			waddr2_q  <= ADDR_W'(req.frame_b) * ADDR_W'(MAX_FRAMES) + ADDR_W'(req.frame_a);
			wdata2_q  <= req.distance;
			pair_ok_q <= pair_ok;
		end
		if (dwe) dist_mem[dwaddr] <= cmd.wr_dist ? req.distance : wdata2_q;
		if (cmd.sw_issue) dist_rd_q <= dist_mem[draddr];
	end

	// Frame info store; entries never written read as zero through their valid bits.
	info_t                 info_mem [MAX_FRAMES];
	logic [MAX_FRAMES-1:0] info_vld_q;
	info_t                 info_rd_q;
	logic                  info_rv_q;
	info_t                 info_eff;
	logic [FR_W-1:0]       iraddr;
	logic                  info_ok;
	logic                  counted_rd;

	assign info_ok = cmd.wr_info && (int'(req.frame_a) < MAX_FRAMES);
	assign iraddr  = cmd.sw_issue ? g_q : f_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			info_vld_q <= '0;
			info_rv_q  <= 1'b0;
		end else begin
			if (info_ok) info_vld_q[req.frame_a] <= 1'b1;
			if (cmd.f_rd || cmd.sw_issue) info_rv_q <= info_vld_q[iraddr];
		end
	end

	always_ff @(posedge clk) begin
		if (info_ok) info_mem[req.frame_a] <= '{req.cluster_id, req.is_present, req.is_assigned};
		if (cmd.f_rd || cmd.sw_issue) info_rd_q <= info_mem[iraddr];
	end

	assign info_eff   = info_rv_q ? info_rd_q : '0;
	assign counted_rd = info_eff.assigned && ({1'b0, info_eff.cluster} < nc) &&
		(incl_q || info_eff.present);

	// Loop counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			f_q <= '0;
			g_q <= '0;
			c_q <= '0;
			j_q <= '0;
		end else begin
			if (cmd.run_init || cmd.c_next) f_q <= '0;
			else if (cmd.f_inc) f_q <= f_q + 1'b1;
			if (cmd.run_init) c_q <= '0;
			else if (cmd.c_next) c_q <= c_q + 1'b1;
			if (cmd.sw_init) g_q <= '0;
			else if (cmd.sw_issue) g_q <= g_q + 1'b1;
			if (cmd.b_init) j_q <= '0;
			else if (cmd.b_step) j_q <= j_q + 1'b1;
		end
	end

	// Per-cluster distance sums, one lane per cluster.
	logic                 issue_s1;
	logic [SUM_W-1:0]     sum_q [MAX_CLUSTERS];
	logic [CNT_W-1:0]     cnt_q [MAX_CLUSTERS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_s1 <= 1'b0;
		end else begin
			issue_s1 <= cmd.sw_issue && (g_q != f_q);
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < MAX_CLUSTERS; k++) begin
			if (cmd.sw_init) begin
				sum_q[k] <= '0;
				cnt_q[k] <= '0;
			end else if (issue_s1 && counted_rd && (int'(info_eff.cluster) == k)) begin
				sum_q[k] <= sum_q[k] + SUM_W'(dist_rd_q);
				cnt_q[k] <= cnt_q[k] + 1'b1;
			end
		end
	end

	// Nearest other cluster, compared as cross-multiplied fractions.
	logic [SUM_W-1:0] sum_j, sa_q, sb_q;
	logic [CNT_W-1:0] cnt_j, na_q, nb_q;
	logic [PRD_W-1:0] lhs, rhs;
	logic             have_b_q;
	logic [PRD_W-1:0] p_q, q_q;

	assign sum_j = sum_q[j_q];
	assign cnt_j = cnt_q[j_q];
	assign lhs   = PRD_W'(sum_j) * PRD_W'(nb_q);
	assign rhs   = PRD_W'(sb_q) * PRD_W'(cnt_j);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_b_q <= 1'b0;
		end else if (cmd.b_init) begin
			have_b_q <= 1'b0;
		end else if (cmd.b_step && (j_q != c_q) && (cnt_j != '0) && (!have_b_q || lhs < rhs)) begin
			have_b_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.b_step) begin
			if (j_q == c_q) begin
				sa_q <= sum_j;
				na_q <= (cnt_j != '0) ? cnt_j : CNT_W'(1);
			end else if ((cnt_j != '0) && (!have_b_q || lhs < rhs)) begin
				sb_q <= sum_j;
				nb_q <= cnt_j;
			end
		end
		if (cmd.pq) begin
			p_q <= PRD_W'(sb_q) * PRD_W'(na_q);
			q_q <= PRD_W'(sa_q) * PRD_W'(nb_q);
		end
	end

	// Restoring divider shared by frame values and cluster averages.
	logic                      avg_mode_q;
	logic                      sign_q;
	logic [PRD_W-1:0]          den_q;
	logic [PRD_W:0]            rem_q;
	logic [QBITS-1:0]          sh_q;
	logic [STEP_W-1:0]         step_q;
	logic signed [AVG_W-1:0]   avg_sum_q;
	logic [CNT_W-1:0]          avg_cnt_q;
	logic                      fsign;
	logic [PRD_W-1:0]          fden, fmag;
	logic [NUM_W-1:0]          fnum, anum, num;
	logic [AVG_W-1:0]          amag;
	logic [PRD_W:0]            trial;
	logic                      ge;
	logic signed [VAL_W-1:0]   qext, dv;

	assign fsign = q_q > p_q;
	assign fden  = fsign ? q_q : p_q;
	assign fmag  = fsign ? q_q - p_q : p_q - q_q;
	assign fnum  = {fmag, 14'b0} + NUM_W'(fden >> 1);
	assign amag  = avg_sum_q[AVG_W-1] ? AVG_W'(-avg_sum_q) : AVG_W'(avg_sum_q);
	assign anum  = NUM_W'(amag) + NUM_W'(avg_cnt_q >> 1);
	assign num   = cmd.div_avg_init ? anum : fnum;
	assign trial = {rem_q[PRD_W-1:0], sh_q[QBITS-1]};
	assign ge    = trial >= {1'b0, den_q};
	assign qext  = VAL_W'(sh_q);
	assign dv    = sign_q ? -qext : qext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			avg_mode_q <= 1'b0;
			step_q     <= '0;
		end else if (cmd.div_frame_init || cmd.div_avg_init) begin
			avg_mode_q <= cmd.div_avg_init;
			step_q     <= '0;
		end else if (cmd.div_step) begin
			step_q <= step_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_frame_init || cmd.div_avg_init) begin
			sign_q <= cmd.div_avg_init ? avg_sum_q[AVG_W-1] : fsign;
			den_q  <= cmd.div_avg_init ? PRD_W'(avg_cnt_q) : fden;
			rem_q  <= {1'b0, num[NUM_W-1:QBITS]};
			sh_q   <= num[QBITS-1:0];
		end else if (cmd.div_step) begin
			rem_q <= ge ? trial - {1'b0, den_q} : trial;
			sh_q  <= {sh_q[QBITS-2:0], ge};
		end
	end

	// Result register and running cluster average.
	logic       res_valid_q;
	res_t       res_q;
	logic       frame_val;
	logic signed [VAL_W-1:0] fval;

	assign frame_val = (cmd.emit_sel == EM_ONE) || ((cmd.emit_sel == EM_DIV) && !avg_mode_q);
	assign fval      = (cmd.emit_sel == EM_ONE) ? VAL_W'(ONE_Q14) : dv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			avg_cnt_q   <= '0;
			avg_sum_q   <= '0;
		end else begin
			res_valid_q <= (cmd.emit_sel != EM_NONE);
			if (cmd.run_init || cmd.c_next) begin
				avg_cnt_q <= '0;
				avg_sum_q <= '0;
			end else if (frame_val) begin
				avg_cnt_q <= avg_cnt_q + 1'b1;
				avg_sum_q <= avg_sum_q + AVG_W'(fval);
			end
		end
	end

	always_ff @(posedge clk) begin
		res_q.cluster_index <= c_q;
		unique case (cmd.emit_sel)
			EM_ONE: begin
				res_q.kind        <= KIND_FRAME;
				res_q.frame_index <= f_q;
				res_q.value       <= VAL_W'(ONE_Q14);
				res_q.last        <= 1'b0;
			end
			EM_SKIP: begin
				res_q.kind        <= KIND_SKIP;
				res_q.frame_index <= f_q;
				res_q.value       <= '0;
				res_q.last        <= 1'b0;
			end
			EM_DIV: begin
				res_q.kind        <= avg_mode_q ? KIND_AVG : KIND_FRAME;
				res_q.frame_index <= avg_mode_q ? '0 : f_q;
				res_q.value       <= dv;
				res_q.last        <= avg_mode_q && sts.c_last;
			end
			EM_AVG0: begin
				res_q.kind        <= KIND_AVG;
				res_q.frame_index <= '0;
				res_q.value       <= '0;
				res_q.last        <= sts.c_last;
			end
			default: ;
		endcase
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

	assign sts.f_last   = (f_q == nf - 1'b1);
	assign sts.g_last   = (g_q == nf - 1'b1);
	assign sts.j_last   = ({1'b0, j_q} == nc - 1'b1);
	assign sts.c_last   = ({1'b0, c_q} == nc - 1'b1);
	assign sts.nf_zero  = (nf == '0);
	assign sts.nc_zero  = (nc == '0);
	assign sts.f_sel    = counted_rd && (info_eff.cluster == c_q);
	assign sts.have_b   = have_b_q;
	assign sts.den_zero = (p_q == '0) && (q_q == '0);
	assign sts.avg_zero = (avg_cnt_q == '0);
	assign sts.div_last = (step_q == STEP_W'(QBITS - 1));
	assign sts.avg_mode = avg_mode_q;

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench of the silhouette engine: random loads, runs and register settings.
`timescale 1ns / 100ps

import cse_pkg::*;

class silhouette_board;
	bit [15:0] dist_mem [MAX_FRAMES*MAX_FRAMES];
	bit        dist_seen [MAX_FRAMES*MAX_FRAMES];
	bit [2:0]  frame_cluster [MAX_FRAMES];
	bit        frame_pres [MAX_FRAMES];
	bit        frame_asg [MAX_FRAMES];
	bit [5:0]  frames_reg = 6'd48;
	bit [3:0]  clusters_reg = 4'd2;
	bit        sieved_reg = 1'b0;
	res_t      silhouettes_due [$];
	int        errors;
	int        checked;

	function void set_reg(logic [1:0] idx, logic [5:0] d);
		case (idx)
			CFG_FRAMES:   frames_reg = d;
			CFG_CLUSTERS: clusters_reg = d[3:0];
			CFG_SIEVED:   sieved_reg = d[0];
			default:      ;
		endcase
	endfunction

	function int frames_eff();
		return (frames_reg > MAX_FRAMES) ? MAX_FRAMES : frames_reg;
	endfunction

	function int clusters_eff();
		return (clusters_reg > MAX_CLUSTERS) ? MAX_CLUSTERS : clusters_reg;
	endfunction

	function bit counted(int f);
		if (f >= frames_eff() || !frame_asg[f]) return 0;
		if (frame_cluster[f] >= clusters_eff()) return 0;
		return sieved_reg || frame_pres[f];
	endfunction

	// Rounds to nearest, ties away from zero.
	function longint round_div(longint num, longint den);
		longint mag;
		mag = (num < 0) ? -num : num;
		mag = (mag + den / 2) / den;
		return (num < 0) ? -mag : mag;
	endfunction

	function void push_result(logic [1:0] kind, int fr, int cl, longint val);
		res_t r;
		r.kind = kind;
		r.frame_index = FR_W'(fr);
		r.cluster_index = CL_W'(cl);
		r.value = val[15:0];
		r.last = 1'b0;
		silhouettes_due = {silhouettes_due, r};
	endfunction

	// Finds a pair of counted frames whose distance was never loaded.
	function bit find_gap(output int fa, output int fb);
		for (int f = 0; f < frames_eff(); f++)
			for (int g = f + 1; g < frames_eff(); g++)
				if (counted(f) && counted(g) && !dist_seen[f*MAX_FRAMES+g]) begin
					fa = f;
					fb = g;
					return 1;
				end
		return 0;
	endfunction

	function void note_request(req_t r);
		longint sum [MAX_CLUSTERS];
		longint cnt [MAX_CLUSTERS];
		longint avg_sum, sa, na, b_sum, b_cnt, p, q, den, val;
		int avg_cnt, first, nf, nc, cg;
		bit have_b;
		if (r.opcode == OP_LOAD_DIST) begin
			if (r.frame_a < MAX_FRAMES && r.frame_b < MAX_FRAMES) begin
				dist_mem[r.frame_a*MAX_FRAMES+r.frame_b] = r.distance;
				dist_mem[r.frame_b*MAX_FRAMES+r.frame_a] = r.distance;
				dist_seen[r.frame_a*MAX_FRAMES+r.frame_b] = 1;
				dist_seen[r.frame_b*MAX_FRAMES+r.frame_a] = 1;
			end
			return;
		end
		if (r.opcode == OP_LOAD_INFO) begin
			if (r.frame_a < MAX_FRAMES) begin
				frame_cluster[r.frame_a] = r.cluster_id;
				frame_pres[r.frame_a] = r.is_present;
				frame_asg[r.frame_a] = r.is_assigned;
			end
			return;
		end
		if (r.opcode != OP_RUN) return;
		nf = frames_eff();
		nc = clusters_eff();
		first = silhouettes_due.size();
		for (int c = 0; c < nc; c++) begin
			avg_sum = 0;
			avg_cnt = 0;
			for (int f = 0; f < nf; f++) begin
				if (!counted(f) || frame_cluster[f] != c) continue;
				for (int j = 0; j < MAX_CLUSTERS; j++) begin
					sum[j] = 0;
					cnt[j] = 0;
				end
				for (int g = 0; g < nf; g++) begin
					if (g == f || !counted(g)) continue;
					cg = frame_cluster[g];
					sum[cg] += dist_mem[f*MAX_FRAMES+g];
					cnt[cg]++;
				end
				sa = sum[c];
				na = cnt[c] ? cnt[c] : 1;
				have_b = 0;
				b_sum = 0;
				b_cnt = 1;
				for (int j = 0; j < nc; j++) begin
					if (j == c || cnt[j] == 0) continue;
					if (!have_b || sum[j] * b_cnt < b_sum * cnt[j]) begin
						b_sum = sum[j];
						b_cnt = cnt[j];
						have_b = 1;
					end
				end
				if (!have_b) val = ONE_Q14;
				else begin
					p = b_sum * na;
					q = sa * b_cnt;
					den = (p > q) ? p : q;
					if (den == 0) begin
						push_result(KIND_SKIP, f, c, 0);
						continue;
					end
					val = round_div((p - q) * ONE_Q14, den);
				end
				push_result(KIND_FRAME, f, c, val);
				avg_sum += val;
				avg_cnt++;
			end
			push_result(KIND_AVG, 0, c, avg_cnt ? round_div(avg_sum, avg_cnt) : 0);
		end
		if (silhouettes_due.size() > first)
			silhouettes_due[silhouettes_due.size()-1].last = 1'b1;
	endfunction

	task report(string msg);
		$display("mismatch: %s", msg);
		errors++;
	endtask

	task check_result(res_t got);
		res_t exp;
		string bad;
		checked++;
		if (silhouettes_due.size() == 0) begin
			report($sformatf("unexpected result %p", got));
			return;
		end
		exp = silhouettes_due.pop_front();
		bad = "";
		if (got.kind !== exp.kind) bad = {bad, " kind"};
		if (got.frame_index !== exp.frame_index) bad = {bad, " frame_index"};
		if (got.cluster_index !== exp.cluster_index) bad = {bad, " cluster_index"};
		if (got.value !== exp.value) bad = {bad, " value"};
		if (got.last !== exp.last) bad = {bad, " last"};
		if (bad != "") report($sformatf("field%s: got %p, want %p", bad, got, exp));
	endtask
endclass

module testbench;
	localparam int LIMIT = 4000000;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	logic       clk;
	logic       arst_n;
	logic       start;
	logic       busy;
	req_t       req;
	logic       cfg_we;
	logic [1:0] cfg_index;
	logic [5:0] cfg_data;
	logic       result_valid;
	res_t       result;

	silhouette_board board;
	int cycles;
	int items;
	int runs;
	int idle_pct;

	cluster_silhouette_engine_unit u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.result_valid(result_valid), .result(result)
	);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	always @(posedge clk)
		if (arst_n && result_valid) board.check_result(result);

	function req_t mk(logic [1:0] op, int fa, int fb, int d, int c, int p, int a);
		req_t r;
		r.opcode = op;
		r.frame_a = FR_W'(fa);
		r.frame_b = FR_W'(fb);
		r.distance = DIST_BITS'(d);
		r.cluster_id = CL_W'(c);
		r.is_present = p[0];
		r.is_assigned = a[0];
		return r;
	endfunction

	function int rand_dist();
		case ($urandom_range(9))
			0: return 0;
			1: return 65535;
			default: return $urandom_range(65535);
		endcase
	endfunction

	task send(req_t r);
		@(negedge clk);
		start <= 1'b1;
		req <= r;
		do @(posedge clk); while (busy);
		board.note_request(r);
		items++;
		if ($urandom_range(99) < idle_pct) begin
			@(negedge clk);
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
	endtask

	// Holds requests off until every expected result is in and the block is quiet.
	task drain();
		@(negedge clk);
		start <= 1'b0;
		while (board.silhouettes_due.size() != 0 || busy) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task cfg_write(logic [1:0] idx, int d);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= 6'(d);
		@(negedge clk);
		cfg_we <= 1'b0;
		board.set_reg(idx, 6'(d));
	endtask

	task configure(int fr, int cl, int sv);
		drain();
		cfg_write(CFG_FRAMES, fr);
		cfg_write(CFG_CLUSTERS, cl);
		cfg_write(CFG_SIEVED, sv);
	endtask

	// Loads any distance a run would read but that was never written, then runs.
	task launch_run();
		int a, b;
		while (board.find_gap(a, b))
			send(mk(OP_LOAD_DIST, a, b, rand_dist(), $urandom_range(7), $urandom_range(1),
				$urandom_range(1)));
		send(mk(OP_RUN, $urandom_range(63), $urandom_range(63), $urandom_range(65535),
			$urandom_range(7), $urandom_range(1), $urandom_range(1)));
		runs++;
	endtask

	initial begin
		int nf, nc, c;
		board = new;
		arst_n = 0;
		start = 0;
		req = '0;
		cfg_we = 0;
		cfg_index = CFG_FRAMES;
		cfg_data = '0;
		idle_pct = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// Nothing assigned yet: only empty cluster averages come out.
		launch_run();
		configure(4, 3, 0);
		send(mk(OP_LOAD_INFO, 0, 0, 0, 0, 1, 1));
		send(mk(OP_LOAD_INFO, 1, 0, 0, 0, 1, 1));
		send(mk(OP_LOAD_INFO, 2, 0, 0, 1, 1, 1));
		send(mk(OP_LOAD_INFO, 3, 0, 0, 2, 0, 1));
		send(mk(OP_LOAD_INFO, 63, 0, 0, 7, 1, 1));
		send(mk(OP_UNUSED, 0, 1, 65535, 7, 1, 1));
		send(mk(OP_LOAD_DIST, 0, 1, 65535, 0, 0, 0));
		send(mk(OP_LOAD_DIST, 0, 2, 0, 0, 0, 0));
		send(mk(OP_LOAD_DIST, 1, 2, 65535, 0, 0, 0));
		send(mk(OP_LOAD_DIST, 63, 0, 5, 0, 0, 0));
		launch_run();
		// All distances zero: every frame hits the zero divisor.
		send(mk(OP_LOAD_DIST, 0, 1, 0, 0, 0, 0));
		send(mk(OP_LOAD_DIST, 1, 2, 0, 0, 0, 0));
		launch_run();
		configure(4, 3, 1);
		launch_run();
		configure(63, 15, 0);
		launch_run();
		// A single cluster in use leaves no other cluster, so each frame scores +1.
		configure(4, 1, 1);
		launch_run();
		configure(0, 0, 0);
		launch_run();

		while (items < 460) begin
			if (items < 160) idle_pct = 0;
			else if (items < 280) idle_pct = 82;
			else if (items < 380) idle_pct = 0;
			else idle_pct = 38;
			if ($urandom_range(3) == 0) begin
				case ($urandom_range(9))
					0: nf = 48;
					1: nf = 63;
					2: nf = 0;
					3: nf = 1;
					default: nf = $urandom_range(2, 10);
				endcase
				case ($urandom_range(9))
					0: nc = 0;
					1: nc = 8;
					2: nc = 15;
					default: nc = $urandom_range(1, 4);
				endcase
				configure(nf, nc, $urandom_range(1));
			end
			nf = (board.frames_eff() > 0) ? board.frames_eff() : 1;
			nc = (board.clusters_eff() > 0) ? board.clusters_eff() : 1;
			repeat ($urandom_range(1, 6)) begin
				c = ($urandom_range(9) < 8) ? $urandom_range(nc - 1) : $urandom_range(7);
				send(mk(OP_LOAD_INFO,
					($urandom_range(15) == 0) ? $urandom_range(63) : $urandom_range(nf - 1),
					$urandom_range(63), $urandom_range(65535), c,
					$urandom_range(3) != 0, $urandom_range(6) != 0));
			end
			repeat ($urandom_range(3))
				send(mk(OP_LOAD_DIST, $urandom_range(63), $urandom_range(63), rand_dist(),
					$urandom_range(7), $urandom_range(1), $urandom_range(1)));
			if ($urandom_range(9) == 0)
				send(mk(OP_UNUSED, $urandom_range(63), $urandom_range(63), $urandom_range(65535),
					$urandom_range(7), $urandom_range(1), $urandom_range(1)));
			launch_run();
			if ($urandom_range(7) == 0) drain();
		end

		drain();
		$display("covered %0d requests in %0d runs, %0d results checked", items, runs,
			board.checked);
		$display("register settings included zero, saturated and single-cluster cases");
		if (board.errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule
